@@ hw/rtl/multi_channel_periodic_timer_core_assert.svh @@
// assertion macros shared by the timer core rtl
// no dependencies; included inside module bodies
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_CORE_ASSERT_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_CORE_ASSERT_SVH

// checked on every clock edge outside reset
`define MCPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define MCPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mcpt_pkg.sv @@
// shared types and constants of the periodic timer core
// no dependencies
`default_nettype none

package mcpt_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int TIME_WIDTH  = 32;
    localparam int NUM_REGS    = 8;
    localparam int PERIOD_W    = 16;
    localparam int CMD_W       = 2;
    localparam int ID_W        = 4;
    localparam int FIRE_TIME_W = 32;
    localparam int REG_IDX_W   = 3;
    localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
        logic            ok;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_rd;

    typedef struct packed {
        logic                   kind;
        logic [ID_W-1:0]        fired_id;
        logic [FIRE_TIME_W-1:0] fire_time;
        logic                   ok;
        logic                   last;
    } t_res;

endpackage

`default_nettype wire

@@ hw/rtl/mcpt_if.sv @@
// command and result stream interfaces of the periodic timer core
// depends on mcpt_pkg
`default_nettype none

interface mcpt_cmd_if;
    import mcpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   timer_id;

    modport source (output valid, output command, output timer_id, input ready);
    modport sink   (input valid, input command, input timer_id, output ready);
endinterface

interface mcpt_res_if;
    import mcpt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [ID_W-1:0]        fired_id;
    logic [FIRE_TIME_W-1:0] fire_time;
    logic                   ok;
    logic                   last;

    modport source (output valid, output kind, output fired_id, output fire_time,
                    output ok, output last, input ready);
    modport sink   (input valid, input kind, input fired_id, input fire_time,
                    input ok, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mcpt_front.sv @@
// front end: accepts command words, decodes and checks the id, pushes to the queue
// depends on mcpt_pkg and mcpt_if
`default_nettype none

module mcpt_front (
    mcpt_cmd_if.sink       i_cmd,
    input  wire logic      i_full,
    output mcpt_pkg::t_q_wr o_wr
);
    import mcpt_pkg::*;

    assign i_cmd.ready = !i_full;

    always_comb begin
        o_wr.cmd.id = i_cmd.timer_id;
        o_wr.cmd.ok = (i_cmd.timer_id < ID_W'(NUM_TIMERS));
        o_wr.cmd.op = OP_TICK;
        o_wr.push   = 1'b0;
        unique case (i_cmd.command)
            OP_START: begin
                o_wr.cmd.op = OP_START;
                o_wr.push   = i_cmd.valid && !i_full;
            end
            OP_STOP: begin
                o_wr.cmd.op = OP_STOP;
                o_wr.push   = i_cmd.valid && !i_full;
            end
            OP_TICK: begin
                o_wr.cmd.op = OP_TICK;
                o_wr.push   = i_cmd.valid && !i_full;
            end
            // unused code: word is taken and dropped
            default: begin
                o_wr.push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcpt_queue.sv @@
// small command queue between the front end and the timer engine
// depends on mcpt_pkg
`default_nettype none

module mcpt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  mcpt_pkg::t_q_wr     i_wr,
    output logic                o_full,
    input  wire logic           i_pop,
    output mcpt_pkg::t_q_rd     o_rd
);
    import mcpt_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;
    logic               w_push, w_pop;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.cmd   = r_mem[r_rd_ptr];

    assign w_push = i_wr.push && !o_full;
    assign w_pop  = i_pop && o_rd.valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(w_push) - Q_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcpt_back.sv @@
// timer engine: period registers, timer state, tick scan and result register
// depends on mcpt_pkg, mcpt_if and the assertion macro header
`default_nettype none

module mcpt_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mcpt_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mcpt_pkg::PERIOD_W-1:0]   i_cfg_data,
    input  mcpt_pkg::t_q_rd                      i_rd,
    output logic                                 o_pop,
    mcpt_res_if.source                           o_res
);
    import mcpt_pkg::*;

    `include "multi_channel_periodic_timer_core_assert.svh"

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_FIRE  = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [NUM_TIMERS-1:0]  r_fire_mask, n_fire_mask;
    logic [TIME_WIDTH-1:0]  r_now;
    logic [PERIOD_W-1:0]    r_period [NUM_REGS];
    logic                   r_running [NUM_TIMERS];
    logic [PERIOD_W-1:0]    r_phase [NUM_TIMERS];
    logic                   r_out_valid;
    t_res                   r_out, n_out;

    logic [PERIOD_W:0]      w_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  w_fire_vec;
    logic [NUM_TIMERS-1:0]  w_rest;
    logic [TIMER_IDX_W-1:0] w_sel;
    logic [TIMER_IDX_W-1:0] w_cmd_idx;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_tick_go;
    logic                   w_cmd_go;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_cmd_idx  = i_rd.cmd.id[TIMER_IDX_W-1:0];
    // clears the lowest pending fire
    assign w_rest     = r_fire_mask & (r_fire_mask - 1'b1);

    // a zero period compares like a period of one
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_next[i]     = {1'b0, r_phase[i]} + 1'b1;
            w_fire_vec[i] = r_running[i] && (w_next[i] >= {1'b0, r_period[i]});
        end
    end

    // lowest pending id goes out first
    always_comb begin
        w_sel = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (r_fire_mask[i]) begin
                w_sel = TIMER_IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fire_mask = r_fire_mask;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_out_load  = 1'b0;
        w_tick_go   = 1'b0;
        w_cmd_go    = 1'b0;
        unique case (r_state)
            ST_FETCH: begin
                if (i_rd.valid) begin
                    unique case (i_rd.cmd.op)
                        OP_TICK: begin
                            o_pop       = 1'b1;
                            w_tick_go   = 1'b1;
                            n_fire_mask = w_fire_vec;
                            if (w_fire_vec != '0) begin
                                n_state = ST_FIRE;
                            end
                        end
                        OP_START, OP_STOP: begin
                            if (w_out_free) begin
                                o_pop           = 1'b1;
                                w_cmd_go        = i_rd.cmd.ok;
                                w_out_load      = 1'b1;
                                n_out.kind      = KIND_ACK;
                                n_out.fired_id  = i_rd.cmd.id;
                                n_out.fire_time = FIRE_TIME_W'(r_now);
                                n_out.ok        = i_rd.cmd.ok;
                                n_out.last      = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_FIRE: begin
                if (w_out_free) begin
                    w_out_load      = 1'b1;
                    n_out.kind      = KIND_FIRE;
                    n_out.fired_id  = ID_W'(w_sel);
                    n_out.fire_time = FIRE_TIME_W'(r_now);
                    n_out.ok        = 1'b1;
                    n_out.last      = (w_rest == '0);
                    n_fire_mask     = w_rest;
                    if (w_rest == '0) begin
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_fire_mask <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_period[i] <= PERIOD_W'(1);
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_running[i] <= 1'b0;
                r_phase[i]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_fire_mask <= n_fire_mask;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_period[i_cfg_idx] <= i_cfg_data;
            end
            if (w_tick_go) begin
                r_now <= r_now + 1'b1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (r_running[i]) begin
                        r_phase[i] <= w_fire_vec[i] ? '0 : w_next[i][PERIOD_W-1:0];
                    end
                end
            end
            if (w_cmd_go) begin
                if (i_rd.cmd.op == OP_START) begin
                    r_running[w_cmd_idx] <= 1'b1;
                    r_phase[w_cmd_idx]   <= '0;
                end else begin
                    r_running[w_cmd_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out.kind;
    assign o_res.fired_id  = r_out.fired_id;
    assign o_res.fire_time = r_out.fire_time;
    assign o_res.ok        = r_out.ok;
    assign o_res.last      = r_out.last;

    `MCPT_ASSERT(a_fire_mask_live, i_clk, i_rst_n, (r_state == ST_FIRE) |-> (r_fire_mask != '0), "fire state with nothing pending")
    `MCPT_ASSERT(a_pop_in_fetch, i_clk, i_rst_n, o_pop |-> (r_state == ST_FETCH), "queue popped during fire scan")
    `MCPT_ASSERT(a_time_step, i_clk, i_rst_n, ($past(i_rst_n) && (r_now != $past(r_now))) |-> (r_now == $past(r_now) + 1'b1), "time moved by more than one tick")

endmodule

`default_nettype wire

@@ hw/rtl/multi_channel_periodic_timer_core.sv @@
// top level of the periodic timer core: front end, command queue, timer engine
// depends on mcpt_pkg, mcpt_if, mcpt_front, mcpt_queue and mcpt_back
`default_nettype none

// Eight periodic timers sharing one 32-bit time base. Commands (start, stop,
// tick) enter through a four-word queue, so the input keeps accepting while
// the engine works. A start or stop yields one acknowledgement word. A tick
// first updates every timer and then emits a fire word for each timer that
// fires; the fire words leave in ascending id order, one per cycle while the
// output is ready, through a single output register, and a tick with no fire
// yields no word. The output register and the fire scan set the rate. The
// user must write period registers through the config port only while the
// block is idle; the block itself does not enforce it. A write to period n
// applies from the next tick on.
module multi_channel_periodic_timer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mcpt_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mcpt_pkg::PERIOD_W-1:0]   i_cfg_data,
    mcpt_cmd_if.sink                             i_cmd,
    mcpt_res_if.source                           o_res
);
    import mcpt_pkg::*;

    t_q_wr w_wr;
    t_q_rd w_rd;
    logic  w_full;
    logic  w_pop;

    mcpt_front u_front (
        .i_cmd  (i_cmd),
        .i_full (w_full),
        .o_wr   (w_wr)
    );

    mcpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rd    (w_rd)
    );

    mcpt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rd       (w_rd),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire
